[design/process_slot_table_macros.svh]
// assertion macros for the process slot table
`ifndef PROCESS_SLOT_TABLE_MACROS_SVH
`define PROCESS_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pst check failed");
`define PST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pst check failed");
`else
`define PST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/pst_pkg.sv]
// shared types, codes and helpers of the process slot table
`default_nettype none
package pst_pkg;

    localparam int PID_W       = 15;
    localparam int SLOT_COUNT_D = 16;
    localparam int PID_LIMIT_D  = 32767;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_TRANS = 3'd1;
    localparam logic [2:0] OP_EXIT  = 3'd2;
    localparam logic [2:0] OP_REAP  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_CREATING = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_EXITED   = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;
    localparam logic [2:0] ST_REAPED   = 3'd6;

    localparam logic [1:0] WM_NONE = 2'd0;
    localparam logic [1:0] WM_ANY  = 2'd1;
    localparam logic [1:0] WM_PID  = 2'd2;

    localparam logic [3:0] STS_OK          = 4'd0;
    localparam logic [3:0] STS_FULL        = 4'd1;
    localparam logic [3:0] STS_BAD_PARENT  = 4'd2;
    localparam logic [3:0] STS_EXHAUSTED   = 4'd3;
    localparam logic [3:0] STS_NOT_FOUND   = 4'd4;
    localparam logic [3:0] STS_ILLEGAL     = 4'd5;
    localparam logic [3:0] STS_NOT_EXIT    = 4'd6;
    localparam logic [3:0] STS_NOT_ZOMBIE  = 4'd7;
    localparam logic [3:0] STS_NO_SLOT     = 4'd8;

    typedef enum logic [2:0] {
        CK_NONE, CK_SCAN_LIVE, CK_SCAN_FREE, CK_WAKE,
        CK_WR_CREATE, CK_WR_STATE, CK_WR_EXIT, CK_WR_FREE
    } t_ckind;

    typedef enum logic [3:0] {
        S_IDLE, S_PARENT, S_NEXT, S_CAND, S_FREE, S_LOOK, S_WRITE, S_WAKE, S_DONE
    } t_fsm;

    typedef struct packed {
        t_ckind      kind;
        logic [2:0]  nst;
        logic [1:0]  wmode;
        logic [14:0] wpid;
        logic [14:0] tpid;
        logic [31:0] code;
    } t_ccmd;

    typedef struct packed {
        logic       tok;
        logic       found;
        logic [2:0] st;
        logic [4:0] cnt;
    } t_wave;

    function automatic logic edge_ok(input logic [2:0] from, input logic [2:0] to);
        logic r;
        r = 1'b0;
        case (from)
            ST_CREATING: r = (to == ST_RUNNABLE) || (to == ST_EXITED);
            ST_RUNNABLE: r = (to == ST_BLOCKED) || (to == ST_EXITED) || (to == ST_ZOMBIE);
            ST_BLOCKED:  r = (to == ST_RUNNABLE) || (to == ST_EXITED) || (to == ST_ZOMBIE);
            ST_EXITED:   r = (to == ST_ZOMBIE);
            ST_ZOMBIE:   r = (to == ST_REAPED);
            ST_REAPED:   r = (to == ST_FREE);
            ST_FREE:     r = (to == ST_CREATING) || (to == ST_RUNNABLE);
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/process_slot_table.sv]
// process slot table top level: sequencer and chain of slot cells
//
//  channel   direction  handshake            payload
//  in        to block   i_valid / o_stall    operation, pids, state, wait, exit code
//  out       from block o_valid / i_stall    status, pid, state, woken count
//  cfg       to block   i_cfg_wr_en          first pid
//
// every table scan walks the cell chain, one cell a cycle
// alloc: parent scan if a parent pid is given, a scan per pid candidate, free slot scan, write, done
// the block goes back to idle before it takes the next item; reset frees all slots at once
// a stalled result holds the block in done, one item at a time
`default_nettype none
`include "process_slot_table_macros.svh"
module process_slot_table #(
    parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_D,
    parameter int PID_LIMIT  = pst_pkg::PID_LIMIT_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [14:0] i_target_pid,
    input  wire logic [2:0]  i_req_state,
    input  wire logic [1:0]  i_wait_mode,
    input  wire logic [14:0] i_wait_pid,
    input  wire logic signed [31:0] i_exit_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_status,
    output logic [14:0]      o_result_pid,
    output logic [2:0]       o_result_state,
    output logic [4:0]       o_woken_count,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [14:0] i_cfg_wr_data
);
    import pst_pkg::*;

    localparam int LW     = $clog2(PID_LIMIT + 1);
    localparam int CW     = (LW > PID_W) ? LW : PID_W;
    localparam int TW     = LW;
    localparam int UW     = $clog2(SLOT_COUNT + 1);
    localparam logic [CW:0]   LIMIT_V = (CW + 1)'(PID_LIMIT);
    localparam logic [TW-1:0] TRIES_V = TW'(PID_LIMIT);
    localparam logic [UW-1:0] FULL_V  = UW'(SLOT_COUNT);

    t_fsm          r_fsm, n_fsm;
    logic [2:0]    r_op;
    logic [14:0]   r_tpid;
    logic [2:0]    r_nst;
    logic [1:0]    r_wmode;
    logic [14:0]   r_wpid;
    logic [31:0]   r_code;
    logic [CW-1:0] r_cand, r_cnt, n_cnt_adv;
    logic [CW:0]   cnt_inc;
    logic [TW-1:0] r_tries;
    logic [UW-1:0] r_used;
    logic          r_start, n_start;
    t_ckind        r_wkind;
    logic [3:0]    r_status;
    logic [14:0]   r_rpid;
    logic [2:0]    r_rstate;
    logic [4:0]    r_woken;
    logic          r_ovalid;

    t_ccmd         cmd;
    logic [CW-1:0] key;
    t_wave         w_chain [SLOT_COUNT+1];
    t_wave         w_end;
    logic          acc, done, out_free, is_scan_n, in_scan;

    assign acc      = i_valid && !o_stall;
    assign o_stall  = (r_fsm != S_IDLE);
    assign w_end    = w_chain[SLOT_COUNT];
    assign done     = w_end.tok;
    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign in_scan  = (r_fsm == S_PARENT) || (r_fsm == S_CAND) || (r_fsm == S_FREE) ||
                      (r_fsm == S_LOOK) || (r_fsm == S_WAKE);

    assign cnt_inc   = {1'b0, r_cnt} + {{CW{1'b0}}, 1'b1};
    assign n_cnt_adv = (cnt_inc > LIMIT_V) ? CW'(2) : cnt_inc[CW-1:0];

    // next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: begin
                if (acc) begin
                    if (i_operation == OP_ALLOC) begin
                        if (r_used >= FULL_V)        n_fsm = S_DONE;
                        else if (i_target_pid != '0) n_fsm = S_PARENT;
                        else                         n_fsm = S_NEXT;
                    end else begin
                        n_fsm = S_LOOK;
                    end
                end
            end
            S_PARENT: if (done) n_fsm = w_end.found ? S_NEXT : S_DONE;
            S_NEXT: begin
                if (r_tries == TRIES_V) n_fsm = S_DONE;
                else if (r_cnt == '0)   n_fsm = S_NEXT;
                else                    n_fsm = S_CAND;
            end
            S_CAND: if (done) n_fsm = w_end.found ? S_NEXT : S_FREE;
            S_FREE: if (done) n_fsm = w_end.found ? S_WRITE : S_DONE;
            S_LOOK: begin
                if (done) begin
                    n_fsm = S_DONE;
                    if (w_end.found) begin
                        case (r_op)
                            OP_TRANS: if (edge_ok(w_end.st, r_nst)) n_fsm = S_WRITE;
                            OP_EXIT:  if (w_end.st != ST_ZOMBIE)    n_fsm = S_WRITE;
                            OP_REAP:  if (w_end.st == ST_ZOMBIE)    n_fsm = S_WRITE;
                            default:  n_fsm = S_DONE;
                        endcase
                    end
                end
            end
            S_WRITE: n_fsm = (r_op == OP_EXIT) ? S_WAKE : S_DONE;
            S_WAKE:  if (done) n_fsm = S_DONE;
            S_DONE:  if (out_free) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    assign is_scan_n = (n_fsm == S_PARENT) || (n_fsm == S_CAND) || (n_fsm == S_FREE) ||
                       (n_fsm == S_LOOK) || (n_fsm == S_WAKE);
    assign n_start   = is_scan_n && (n_fsm != r_fsm);

    // cell command
    always_comb begin
        cmd.nst   = r_nst;
        cmd.wmode = r_wmode;
        cmd.wpid  = r_wpid;
        cmd.tpid  = r_tpid;
        cmd.code  = r_code;
        cmd.kind  = CK_NONE;
        key       = CW'(r_tpid);
        unique case (r_fsm)
            S_PARENT, S_LOOK: cmd.kind = CK_SCAN_LIVE;
            S_CAND: begin
                cmd.kind = CK_SCAN_LIVE;
                key      = r_cand;
            end
            S_FREE:  cmd.kind = CK_SCAN_FREE;
            S_WAKE:  cmd.kind = CK_WAKE;
            S_WRITE: begin
                cmd.kind = r_wkind;
                key      = r_cand;
            end
            default: cmd.kind = CK_NONE;
        endcase
    end

    assign w_chain[0] = '{tok: r_start, found: 1'b0, st: ST_FREE, cnt: 5'd0};

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        pst_cell #(.PID_CW(CW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (cmd),
            .i_key  (key),
            .i_wave (w_chain[g]),
            .o_wave (w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_start  <= 1'b0;
            r_used   <= '0;
            r_cnt    <= CW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_start  <= n_start;
            r_ovalid <= ((r_fsm == S_DONE) && out_free) || (r_ovalid && i_stall);
            if (i_cfg_wr_en) begin
                r_cnt <= CW'(i_cfg_wr_data);
            end else if ((r_fsm == S_NEXT) && (r_tries != TRIES_V)) begin
                r_cnt <= n_cnt_adv;
            end
            unique case (r_fsm)
                S_FREE: if (done && w_end.found) r_used <= r_used + UW'(1);
                S_LOOK: begin
                    if (done && w_end.found && (r_op == OP_REAP) &&
                        (w_end.st == ST_ZOMBIE) && (r_used != '0)) begin
                        r_used <= r_used - UW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_fsm)
            S_IDLE: begin
                if (acc) begin
                    r_op     <= i_operation;
                    r_tpid   <= i_target_pid;
                    r_nst    <= i_req_state;
                    r_wmode  <= i_wait_mode;
                    r_wpid   <= i_wait_pid;
                    r_code   <= i_exit_code;
                    r_tries  <= '0;
                    r_rpid   <= '0;
                    r_rstate <= ST_FREE;
                    r_woken  <= '0;
                    r_status <= ((i_operation == OP_ALLOC) && (r_used >= FULL_V)) ?
                                STS_FULL : STS_OK;
                end
            end
            S_PARENT: if (done && !w_end.found) r_status <= STS_BAD_PARENT;
            S_NEXT: begin
                if (r_tries == TRIES_V) begin
                    r_status <= STS_EXHAUSTED;
                end else begin
                    r_cand  <= r_cnt;
                    r_tries <= r_tries + TW'(1);
                end
            end
            S_FREE: begin
                if (done) begin
                    if (w_end.found) begin
                        r_wkind  <= CK_WR_CREATE;
                        r_rpid   <= r_cand[14:0];
                        r_rstate <= ST_CREATING;
                    end else begin
                        r_status <= STS_NO_SLOT;
                    end
                end
            end
            S_LOOK: begin
                if (done) begin
                    if (!w_end.found) begin
                        r_status <= STS_NOT_FOUND;
                    end else begin
                        case (r_op)
                            OP_TRANS: begin
                                if (edge_ok(w_end.st, r_nst)) begin
                                    r_wkind  <= CK_WR_STATE;
                                    r_rpid   <= r_tpid;
                                    r_rstate <= r_nst;
                                end else begin
                                    r_status <= STS_ILLEGAL;
                                    r_rstate <= w_end.st;
                                end
                            end
                            OP_EXIT: begin
                                if (w_end.st == ST_ZOMBIE) begin
                                    r_status <= STS_NOT_EXIT;
                                    r_rstate <= ST_ZOMBIE;
                                end else begin
                                    r_wkind  <= CK_WR_EXIT;
                                    r_rpid   <= r_tpid;
                                    r_rstate <= edge_ok(w_end.st, ST_ZOMBIE) ?
                                                ST_ZOMBIE : w_end.st;
                                end
                            end
                            OP_REAP: begin
                                if (w_end.st != ST_ZOMBIE) begin
                                    r_status <= STS_NOT_ZOMBIE;
                                    r_rstate <= w_end.st;
                                end else begin
                                    r_wkind  <= CK_WR_FREE;
                                    r_rpid   <= r_tpid;
                                    r_rstate <= ST_FREE;
                                end
                            end
                            default: begin
                                r_rpid   <= r_tpid;
                                r_rstate <= w_end.st;
                            end
                        endcase
                    end
                end
            end
            S_WAKE: if (done) r_woken <= w_end.cnt;
            S_DONE: begin
                if (out_free) begin
                    o_status       <= r_status;
                    o_result_pid   <= r_rpid;
                    o_result_state <= r_rstate;
                    o_woken_count  <= r_woken;
                end
            end
            default: begin
            end
        endcase
    end

    `PST_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= FULL_V)
    `PST_ASSERT_IMP(a_scan_end, i_clk, i_rst_n, done, in_scan)
    `PST_ASSERT_NXT(a_write_once, i_clk, i_rst_n, r_fsm == S_WRITE, r_fsm != S_WRITE)
    `PST_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, acc, r_fsm != S_IDLE)

endmodule
`default_nettype wire

[design/pst_cell.sv]
// one slot of the table, a stage of the scan chain
`default_nettype none
module pst_cell #(
    parameter int PID_CW = 15
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pst_pkg::t_ccmd    i_cmd,
    input  wire logic [PID_CW-1:0] i_key,
    input  wire pst_pkg::t_wave    i_wave,
    output pst_pkg::t_wave         o_wave
);
    import pst_pkg::*;

    logic [2:0]        r_st, n_st;
    logic              r_sel, n_sel;
    logic [PID_CW-1:0] r_pid, n_pid;
    logic [14:0]       r_parent, n_parent;
    logic [1:0]        r_wm, n_wm;
    logic [14:0]       r_wpid, n_wpid;
    logic [31:0]       r_code, n_code;
    t_wave             r_wave, n_wave;
    logic              live, hit;

    assign live = (r_st != ST_FREE) && (r_st != ST_REAPED);

    always_comb begin
        n_st     = r_st;
        n_sel    = r_sel;
        n_pid    = r_pid;
        n_parent = r_parent;
        n_wm     = r_wm;
        n_wpid   = r_wpid;
        n_code   = r_code;
        n_wave   = i_wave;
        hit      = 1'b0;
        case (i_cmd.kind)
            CK_SCAN_LIVE, CK_SCAN_FREE: begin
                if (i_wave.tok) begin
                    if (i_cmd.kind == CK_SCAN_LIVE) begin
                        hit = live && (r_pid == i_key) && (i_key != '0);
                    end else begin
                        hit = (r_st == ST_FREE);
                    end
                    n_sel = hit && !i_wave.found;
                    if (n_sel) begin
                        n_wave.found = 1'b1;
                        n_wave.st    = r_st;
                    end
                end
            end
            CK_WAKE: begin
                if (i_wave.tok && (r_st == ST_BLOCKED) &&
                    ((r_wm == WM_ANY) || ((r_wm == WM_PID) && (r_wpid == i_cmd.tpid)))) begin
                    n_st = ST_RUNNABLE;
                    n_wm = WM_NONE;
                    n_wpid = '0;
                    n_wave.cnt = i_wave.cnt + 5'd1;
                end
            end
            CK_WR_CREATE: begin
                if (r_sel) begin
                    n_st     = ST_CREATING;
                    n_pid    = i_key;
                    n_parent = i_cmd.tpid;
                    n_wm     = WM_NONE;
                    n_wpid   = '0;
                    n_code   = '0;
                end
            end
            CK_WR_STATE: begin
                if (r_sel) begin
                    n_st = i_cmd.nst;
                    if (i_cmd.nst == ST_BLOCKED) begin
                        n_wm   = i_cmd.wmode;
                        n_wpid = i_cmd.wpid;
                    end else begin
                        n_wm   = WM_NONE;
                        n_wpid = '0;
                    end
                end
            end
            CK_WR_EXIT: begin
                if (r_sel) begin
                    n_code = i_cmd.code;
                    if (edge_ok(r_st, ST_ZOMBIE)) begin
                        n_st = ST_ZOMBIE;
                    end
                    n_wm   = WM_NONE;
                    n_wpid = '0;
                end
            end
            CK_WR_FREE: begin
                if (r_sel) begin
                    n_st     = ST_FREE;
                    n_pid    = '0;
                    n_parent = '0;
                    n_wm     = WM_NONE;
                    n_wpid   = '0;
                    n_code   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_FREE;
            r_sel      <= 1'b0;
            r_wave.tok <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_sel      <= n_sel;
            r_wave.tok <= n_wave.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid        <= n_pid;
        r_parent     <= n_parent;
        r_wm         <= n_wm;
        r_wpid       <= n_wpid;
        r_code       <= n_code;
        r_wave.found <= n_wave.found;
        r_wave.st    <= n_wave.st;
        r_wave.cnt   <= n_wave.cnt;
    end

    assign o_wave = r_wave;

endmodule
`default_nettype wire

[tb/pst_checker.sv]
// checker for the process slot table: predicts each result and compares it
module pst_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [14:0] i_target_pid,
    input  wire logic [2:0]  i_req_state,
    input  wire logic [1:0]  i_wait_mode,
    input  wire logic [14:0] i_wait_pid,
    input  wire logic [31:0] i_exit_code,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [3:0]  i_status,
    input  wire logic [14:0] i_result_pid,
    input  wire logic [2:0]  i_result_state,
    input  wire logic [4:0]  i_woken_count,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [14:0] i_cfg_wr_data,
    output int               o_fail_count,
    output int               o_pending
);
    import pst_pkg::*;

    localparam int NSLOT = SLOT_COUNT_D;

    typedef struct packed {
        logic [3:0]  status;
        logic [14:0] pid;
        logic [2:0]  state;
        logic [4:0]  woken;
    } t_reply;

    logic [2:0]  tbl_state [NSLOT];
    logic [14:0] tbl_pid [NSLOT];
    logic [14:0] tbl_parent [NSLOT];
    logic [1:0]  tbl_wmode [NSLOT];
    logic [14:0] tbl_wpid [NSLOT];
    logic [31:0] tbl_code [NSLOT];
    int          live_count;
    logic [14:0] pid_next;
    t_reply      replies_due [$];

    function automatic int find_live(input logic [14:0] pid);
        if (pid == 0) return -1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_state[i] != ST_FREE && tbl_state[i] != ST_REAPED && tbl_pid[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic bit move_legal(input logic [2:0] from, input logic [2:0] to);
        case (from)
            ST_CREATING: return to == ST_RUNNABLE || to == ST_EXITED;
            ST_RUNNABLE: return to == ST_BLOCKED || to == ST_EXITED || to == ST_ZOMBIE;
            ST_BLOCKED:  return to == ST_RUNNABLE || to == ST_EXITED || to == ST_ZOMBIE;
            ST_EXITED:   return to == ST_ZOMBIE;
            ST_ZOMBIE:   return to == ST_REAPED;
            ST_REAPED:   return to == ST_FREE;
            ST_FREE:     return to == ST_CREATING || to == ST_RUNNABLE;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic [14:0] claim_pid();
        logic [14:0] cand;
        for (int t = 0; t < PID_LIMIT_D; t++) begin
            cand = pid_next;
            pid_next = (pid_next == 15'(PID_LIMIT_D)) ? 15'd2 : pid_next + 15'd1;
            if (cand != 0 && find_live(cand) < 0) return cand;
        end
        return 15'd0;
    endfunction

    function automatic t_reply run_op(input logic [2:0] op, input logic [14:0] tpid,
                                      input logic [2:0] nst, input logic [1:0] wm,
                                      input logic [14:0] wp, input logic [31:0] code);
        t_reply r;
        int s;
        logic [14:0] pid;
        r = '0;
        if (op == OP_ALLOC) begin
            if (live_count >= NSLOT) r.status = STS_FULL;
            else if (tpid != 0 && find_live(tpid) < 0) r.status = STS_BAD_PARENT;
            else begin
                pid = claim_pid();
                if (pid == 0) r.status = STS_EXHAUSTED;
                else begin
                    r.status = STS_NO_SLOT;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (tbl_state[i] == ST_FREE) begin
                            tbl_state[i] = ST_CREATING;
                            tbl_pid[i] = pid;
                            tbl_parent[i] = tpid;
                            tbl_wmode[i] = WM_NONE;
                            tbl_wpid[i] = 0;
                            tbl_code[i] = 0;
                            live_count++;
                            r.status = STS_OK;
                            r.pid = pid;
                            r.state = ST_CREATING;
                            break;
                        end
                    end
                end
            end
            return r;
        end
        s = find_live(tpid);
        if (s < 0) begin
            r.status = STS_NOT_FOUND;
        end else if (op == OP_TRANS) begin
            if (!move_legal(tbl_state[s], nst)) begin
                r.status = STS_ILLEGAL;
                r.state = tbl_state[s];
            end else begin
                tbl_state[s] = nst;
                tbl_wmode[s] = (nst == ST_BLOCKED) ? wm : WM_NONE;
                tbl_wpid[s] = (nst == ST_BLOCKED) ? wp : 15'd0;
                r.pid = tpid;
                r.state = nst;
            end
        end else if (op == OP_EXIT) begin
            if (tbl_state[s] == ST_ZOMBIE) begin
                r.status = STS_NOT_EXIT;
                r.state = ST_ZOMBIE;
            end else begin
                tbl_code[s] = code;
                if (move_legal(tbl_state[s], ST_ZOMBIE)) tbl_state[s] = ST_ZOMBIE;
                tbl_wmode[s] = WM_NONE;
                tbl_wpid[s] = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_state[i] == ST_BLOCKED && (tbl_wmode[i] == WM_ANY ||
                        (tbl_wmode[i] == WM_PID && tbl_wpid[i] == tpid))) begin
                        tbl_state[i] = ST_RUNNABLE;
                        tbl_wmode[i] = WM_NONE;
                        tbl_wpid[i] = 0;
                        r.woken++;
                    end
                end
                r.pid = tpid;
                r.state = tbl_state[s];
            end
        end else if (op == OP_REAP) begin
            if (tbl_state[s] != ST_ZOMBIE) begin
                r.status = STS_NOT_ZOMBIE;
                r.state = tbl_state[s];
            end else begin
                tbl_state[s] = ST_FREE;
                tbl_pid[s] = 0;
                tbl_parent[s] = 0;
                tbl_wmode[s] = WM_NONE;
                tbl_wpid[s] = 0;
                tbl_code[s] = 0;
                if (live_count > 0) live_count--;
                r.pid = tpid;
                r.state = ST_FREE;
            end
        end else begin
            r.pid = tpid;
            r.state = tbl_state[s];
        end
        return r;
    endfunction

    assign o_pending = replies_due.size();

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_state[i] = ST_FREE;
                tbl_pid[i] = 0;
                tbl_parent[i] = 0;
                tbl_wmode[i] = WM_NONE;
                tbl_wpid[i] = 0;
                tbl_code[i] = 0;
            end
            live_count = 0;
            pid_next = 15'd1;
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en) pid_next = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_result_pid !== want.pid) begin
                        $error("result_pid expected %0d actual %0d", want.pid, i_result_pid);
                        o_fail_count++;
                    end
                    if (i_result_state !== want.state) begin
                        $error("result_state expected %0d actual %0d", want.state,
                               i_result_state);
                        o_fail_count++;
                    end
                    if (i_woken_count !== want.woken) begin
                        $error("woken_count expected %0d actual %0d", want.woken,
                               i_woken_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                replies_due.push_back(run_op(i_operation, i_target_pid, i_req_state,
                                             i_wait_mode, i_wait_pid, i_exit_code));
        end
    end

    initial o_fail_count = 0;
endmodule

[tb/tb_process_slot_table.sv]
// testbench top for the process slot table: stimulus, idling and verdict
module tb_process_slot_table;
    import pst_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [14:0] target_pid;
    logic [2:0]  req_state;
    logic [1:0]  wait_mode;
    logic [14:0] wait_pid;
    logic [31:0] exit_code;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  status;
    logic [14:0] result_pid;
    logic [2:0]  result_state;
    logic [4:0]  woken_count;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    int          fail_count;
    int          pending;

    logic [14:0] pid_pool [$];
    bit          calm;
    bit          hold_req;

    process_slot_table u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_operation(operation), .i_target_pid(target_pid), .i_req_state(req_state),
        .i_wait_mode(wait_mode), .i_wait_pid(wait_pid), .i_exit_code(exit_code),
        .o_valid(out_valid), .i_stall(out_stall), .o_status(status),
        .o_result_pid(result_pid), .o_result_state(result_state),
        .o_woken_count(woken_count), .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data)
    );

    pst_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_operation(operation), .i_target_pid(target_pid), .i_req_state(req_state),
        .i_wait_mode(wait_mode), .i_wait_pid(wait_pid), .i_exit_code(exit_code),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_status(status),
        .i_result_pid(result_pid), .i_result_state(result_state),
        .i_woken_count(woken_count), .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // pool of pids seen created, used to aim items at slots that may still be live
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && status == STS_OK &&
            result_state == ST_CREATING && result_pid != 0) begin
            if (!(result_pid inside {pid_pool})) pid_pool.push_back(result_pid);
            if (pid_pool.size() > 24) void'(pid_pool.pop_front());
        end
    end

    initial begin
        int hold;
        out_stall = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 0;
                out_stall <= 1;
                for (hold = 0; hold < 300; hold++) @(negedge clk);
                out_stall <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    function automatic logic [14:0] pick_pid();
        if (pid_pool.size() > 0 && $urandom_range(0, 9) < 8)
            return pid_pool[$urandom_range(0, pid_pool.size() - 1)];
        return 15'($urandom);
    endfunction

    task automatic send(input logic [2:0] op, input logic [14:0] tpid,
                        input logic [2:0] nst, input logic [1:0] wm,
                        input logic [14:0] wp, input logic [31:0] code);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1;
        operation <= op;
        target_pid <= tpid;
        req_state <= nst;
        wait_mode <= wm;
        wait_pid <= wp;
        exit_code <= code;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        wait (pending == 0);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_first_pid(input logic [14:0] value);
        cfg_wr_en <= 1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 0;
        pid_pool.delete();
    endtask

    task automatic random_item(input int alloc_weight);
        logic [2:0] op;
        logic [2:0] nst;
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_weight) op = OP_ALLOC;
        else if (r < 45 + alloc_weight / 2) op = OP_TRANS;
        else if (r < 65 + alloc_weight / 3) op = OP_EXIT;
        else if (r < 85 + alloc_weight / 8) op = OP_REAP;
        else op = 3'($urandom_range(4, 7));
        nst = ($urandom_range(0, 7) == 0) ? 3'($urandom) :
              3'($urandom_range(ST_RUNNABLE, ST_ZOMBIE));
        send(op, (op == OP_ALLOC && $urandom_range(0, 1)) ? 15'd0 : pick_pid(), nst,
             ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
             ($urandom_range(0, 3) == 0) ? 15'($urandom) : pick_pid(), $urandom);
    endtask

    initial begin
        logic [14:0] p0;
        logic [14:0] p1;
        rst_n = 0;
        in_valid = 0;
        operation = 0;
        target_pid = 0;
        req_state = 0;
        wait_mode = 0;
        wait_pid = 0;
        exit_code = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        calm = 0;
        hold_req = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // counter starts at the top and wraps to 2
        set_first_pid(15'd32767);
        send(OP_ALLOC, 0, 0, 0, 0, 0);
        send(OP_ALLOC, 0, 0, 0, 0, 0);
        drain();
        p0 = 15'd32767;
        p1 = 15'd2;
        send(OP_ALLOC, p0, 0, 0, 0, 0);
        send(OP_ALLOC, 15'd12345, 0, 0, 0, 0);
        send(OP_TRANS, p1, ST_RUNNABLE, 0, 0, 0);
        send(OP_TRANS, p1, ST_BLOCKED, WM_ANY, 15'h7fff, 0);
        send(OP_TRANS, p0, ST_BLOCKED, WM_ANY, 0, 0);
        send(OP_EXIT, p0, 0, 0, 0, 32'h7fffffff);
        send(OP_TRANS, p0, ST_RUNNABLE, 0, 0, 0);
        send(OP_TRANS, p0, ST_BLOCKED, WM_PID, p1, 0);
        send(OP_EXIT, p1, 3'd7, 2'd3, 0, 32'h80000000);
        send(OP_EXIT, p1, 0, 0, 0, 32'hffffffff);
        send(OP_REAP, p0, 0, 0, 0, 0);
        send(OP_REAP, p1, 0, 0, 0, 0);
        send(OP_QUERY, p1, 0, 0, 0, 0);
        send(3'd7, p0, 0, 0, 0, 0);
        send(OP_QUERY, 15'd0, 0, 0, 0, 0);
        send(OP_TRANS, p0, 3'd7, 0, 0, 0);
        send(OP_TRANS, p0, ST_EXITED, 0, 0, 0);
        send(OP_TRANS, p0, ST_ZOMBIE, 0, 0, 0);
        send(OP_TRANS, p0, ST_REAPED, 0, 0, 0);
        send(OP_TRANS, p0, ST_FREE, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_first_pid(15'd1);
                1: set_first_pid(15'd32766);
                2: set_first_pid(15'($urandom_range(1, 32767)));
                default: set_first_pid(15'd32767);
            endcase
            for (int n = 0; n < 350; n++) begin
                if (ph == 1 && n == 100) hold_req = 1;
                if (ph == 3 && n == 200) calm = 1;
                random_item((ph == 2) ? 60 : 30);
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/pst_pkg.sv
design/pst_cell.sv
design/process_slot_table.sv
tb/pst_checker.sv
tb/tb_process_slot_table.sv
